// ===== src/dwpi_pkg.sv =====
// Shared constants for the dual-wheel PI speed controller.
// Request and register codes, fixed field widths and the arithmetic scale factors.
// No dependencies.
package dwpi_pkg;

  // request kinds carried in s_axis_tuser
  localparam logic [1:0] REQ_LEFT  = 2'd0;
  localparam logic [1:0] REQ_RIGHT = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE_MASK = 3'd0;
  localparam logic [2:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [2:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [2:0] CFG_DIFF_GAIN   = 3'd3;
  localparam logic [2:0] CFG_INTEG_LIMIT = 3'd4;
  localparam logic [2:0] CFG_DIR_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_OUT_LIMIT   = 3'd6;

  // register reset values
  localparam logic [1:0]  RST_ENABLE_MASK = 2'd0;
  localparam logic [7:0]  RST_PROP_GAIN   = 8'd40;
  localparam logic [7:0]  RST_INTEG_GAIN  = 8'd2;
  localparam logic [7:0]  RST_DIFF_GAIN   = 8'd0;
  localparam logic [14:0] RST_INTEG_LIMIT = 15'd5000;
  localparam logic [14:0] RST_DIR_LIMIT   = 15'd32767;
  localparam logic [14:0] RST_OUT_LIMIT   = 15'd10000;

  // arithmetic constants
  localparam int SPEED_SCALE = 50;
  localparam int DIR_DIVISOR = 10;
  localparam int OUT_DIVISOR = 20;
  localparam logic [9:0] DRIVE_MAX = 10'd500;

  // shared reciprocal divider: dividend magnitude width, reciprocal width and shift
  localparam int DIV_W     = 20;
  localparam int RCP_W     = 27;
  localparam int RCP_SHIFT = 27;
  localparam longint DRV_DIVISOR = DIR_DIVISOR * OUT_DIVISOR;
  localparam logic [RCP_W-1:0] DRV_RCP =
    RCP_W'(((longint'(1) <<< RCP_SHIFT) + DRV_DIVISOR - 1) / DRV_DIVISOR);

endpackage

// ===== src/dual_wheel_pi_speed_controller.sv =====
// Dual-wheel PI(D) speed controller: history memory, sequencer, shared multiplier and divider.
// One item is in work at a time: a word is taken only with the sequencer idle, and the history
// sum reads one entry per cycle. Enabled ticks also run the PI(D) update and drive division;
// disabled ticks give speed only; clear and unused requests go straight to the output.
// Reset (rst, synchronous) restores register defaults, zeroes integrators, errors, slots,
// and clears the history valid bits so unwritten history reads 0.
module dual_wheel_pi_speed_controller
  import dwpi_pkg::*;
#(
  parameter int HIST_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] tick_count, [23:8] target_speed
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [13:0] measured_speed, [23:14] drive
  output logic [1:0]  m_axis_tuser,   // [0] side, [1] drive_valid
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int ENTRIES = 2 * HIST_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W   = $clog2((HIST_DEPTH + 1) * 128) + 1;
  localparam longint SPD_DIVISOR = HIST_DEPTH + 1;
  localparam logic [RCP_W-1:0] SPD_RCP =
    RCP_W'(((longint'(1) <<< RCP_SHIFT) + SPD_DIVISOR - 1) / SPD_DIVISOR);
  localparam logic signed [DIV_W:0] SCALE_S = (DIV_W+1)'(SPEED_SCALE);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_SPD  = 4'd2;
  localparam logic [3:0] S_SPDW = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_MP   = 4'd5;
  localparam logic [3:0] S_MI   = 4'd6;
  localparam logic [3:0] S_MD   = 4'd7;
  localparam logic [3:0] S_X    = 4'd8;
  localparam logic [3:0] S_XC   = 4'd9;
  localparam logic [3:0] S_DRVW = 4'd10;
  localparam logic [3:0] S_WB   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // configuration
  logic [1:0]  enable_mask;
  logic [7:0]  prop_gain;
  logic [7:0]  integ_gain;
  logic [7:0]  diff_gain;
  logic [14:0] integ_limit;
  logic [14:0] dir_limit;
  logic [14:0] out_limit;

  // sequencer and item registers
  logic [3:0]        state;
  logic [3:0]        state_next;
  logic              side;
  logic signed [7:0] tick;
  logic signed [15:0] target;
  logic [CNT_W-1:0]  cnt;
  logic signed [SUM_W-1:0] sum_acc;

  // history memory and its valid bits
  logic [7:0]        hist_mem [ENTRIES];
  logic [ENTRIES-1:0] hist_vld;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] base;
  logic [7:0]        rd_data;
  logic              rd_ok;
  logic              rd_issue;
  logic              wr_en;

  // controller state
  logic [SLOT_W-1:0]  slot [2];
  logic signed [15:0] integ [2];
  logic signed [17:0] prev_err [2];
  logic signed [15:0] dir_integ;

  // datapath
  logic signed [17:0] err;
  logic signed [18:0] dif;
  logic signed [17:0] err_r;
  logic signed [18:0] dif_r;
  logic signed [8:0]  mul_g;
  logic signed [18:0] mul_op;
  logic signed [27:0] mul_p;
  logic signed [27:0] acc;
  logic signed [31:0] x_r;
  logic signed [31:0] lim10;
  logic signed [31:0] xc;
  logic signed [DIV_W:0] spd_prod;
  logic               neg;

  // divider
  logic [DIV_W-1:0]       div_n;
  logic [RCP_W-1:0]       div_m;
  logic [DIV_W+RCP_W-1:0] div_prod;
  logic [DIV_W-1:0]       div_quo;
  logic                   div_busy;
  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic [RCP_W-1:0]       div_recip;

  // result register
  logic               res_side;
  logic signed [13:0] res_speed;
  logic               res_dv;
  logic signed [9:0]  res_drive;
  logic               out_valid;
  logic               out_side;
  logic [13:0]        out_speed;
  logic               out_dv;
  logic [9:0]         out_drive;

  logic in_acc;
  logic side_en;
  logic out_free;

  function automatic logic signed [15:0] clamp_lim(input logic signed [18:0] v,
                                                   input logic [14:0] lim);
    logic signed [18:0] l;
    l = $signed({4'b0, lim});
    if (v > l) return 16'(l);
    if (v < -l) return 16'(-l);
    return 16'(v);
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;
  assign side_en       = side ? enable_mask[1] : enable_mask[0];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_drive, out_speed};
  assign m_axis_tuser  = {out_dv, out_side};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= RST_ENABLE_MASK;
      prop_gain   <= RST_PROP_GAIN;
      integ_gain  <= RST_INTEG_GAIN;
      diff_gain   <= RST_DIFF_GAIN;
      integ_limit <= RST_INTEG_LIMIT;
      dir_limit   <= RST_DIR_LIMIT;
      out_limit   <= RST_OUT_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE_MASK: enable_mask <= cfg_data[1:0];
        CFG_PROP_GAIN:   prop_gain   <= cfg_data[7:0];
        CFG_INTEG_GAIN:  integ_gain  <= cfg_data[7:0];
        CFG_DIFF_GAIN:   diff_gain   <= cfg_data[7:0];
        CFG_INTEG_LIMIT: integ_limit <= cfg_data;
        CFG_DIR_LIMIT:   dir_limit   <= cfg_data;
        CFG_OUT_LIMIT:   out_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // history memory addressing
  assign base     = side ? ADDR_W'(HIST_DEPTH) : '0;
  assign rd_addr  = base + ADDR_W'(cnt);
  assign wr_addr  = base + ADDR_W'(slot[side]);
  assign rd_issue = (state == S_SUM) && (cnt < CNT_W'(HIST_DEPTH));
  assign wr_en    = (state == S_WB);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= tick;
    end
    rd_data <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      rd_ok    <= 1'b0;
    end else begin
      rd_ok <= rd_issue && hist_vld[rd_addr];
      if (wr_en) begin
        hist_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // shared divider by a constant: multiply by the rounded-up reciprocal and shift, exact for
  // the dividend ranges used here; operands are registered at start, then their quotient.
  assign spd_prod = (DIV_W+1)'(sum_acc) * SCALE_S;
  assign lim10    = $signed({17'b0, out_limit}) * 32'sd10 + 32'sd9;
  assign xc       = (x_r > lim10) ? lim10 : ((x_r < -lim10) ? -lim10 : x_r);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_recip    = SPD_RCP;
    if (state == S_SPD) begin
      div_start    = 1'b1;
      div_dividend = spd_prod[DIV_W] ? DIV_W'(-spd_prod) : DIV_W'(spd_prod);
    end else if (state == S_XC) begin
      div_start    = 1'b1;
      div_dividend = xc[31] ? DIV_W'(-xc) : DIV_W'(xc);
      div_recip    = DRV_RCP;
    end
  end

  assign div_prod = div_n * div_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else begin
      div_busy <= div_start;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_n <= div_dividend;
      div_m <= div_recip;
    end
    div_quo <= DIV_W'(div_prod >> RCP_SHIFT);
  end

  // error terms and the shared multiplier
  assign err = 18'(target) - 18'(res_speed);
  assign dif = 19'(err) - 19'(prev_err[side]);

  always_comb begin
    case (state)
      S_MI: begin
        mul_g  = $signed({1'b0, integ_gain});
        mul_op = 19'(integ[side]);
      end
      S_MD: begin
        mul_g  = $signed({1'b0, diff_gain});
        mul_op = dif_r;
      end
      default: begin
        mul_g  = $signed({1'b0, prop_gain});
        mul_op = 19'(err_r);
      end
    endcase
  end

  assign mul_p = mul_g * mul_op;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == REQ_LEFT || s_axis_tuser == REQ_RIGHT) begin
            state_next = S_SUM;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SUM:  if (cnt == CNT_W'(HIST_DEPTH)) state_next = S_SPD;
      S_SPD:  state_next = S_SPDW;
      S_SPDW: if (!div_busy) state_next = side_en ? S_ERR : S_WB;
      S_ERR:  state_next = S_MP;
      S_MP:   state_next = S_MI;
      S_MI:   state_next = S_MD;
      S_MD:   state_next = S_X;
      S_X:    state_next = S_XC;
      S_XC:   state_next = S_DRVW;
      S_DRVW: if (!div_busy) state_next = S_WB;
      S_WB:   state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot[0]   <= '0;
      slot[1]   <= '0;
      integ[0]  <= '0;
      integ[1]  <= '0;
      prev_err[0] <= '0;
      prev_err[1] <= '0;
      dir_integ <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc && s_axis_tuser == REQ_CLEAR) begin
            integ[0]  <= '0;
            integ[1]  <= '0;
            dir_integ <= '0;
          end
        end
        S_ERR: begin
          prev_err[side] <= err;
          integ[side]    <= clamp_lim(19'(integ[side]) + 19'(err), integ_limit);
          dir_integ      <= clamp_lim(19'(dir_integ) + (side ? -19'(err) : 19'(err)),
                                      dir_limit);
        end
        S_WB: begin
          if (slot[side] == SLOT_W'(HIST_DEPTH - 1)) begin
            slot[side] <= '0;
          end else begin
            slot[side] <= slot[side] + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // item payload and datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          side      <= (s_axis_tuser == REQ_RIGHT);
          tick      <= s_axis_tdata[7:0];
          target    <= s_axis_tdata[23:8];
          cnt       <= '0;
          sum_acc   <= SUM_W'(signed'(s_axis_tdata[7:0]));
          res_side  <= (s_axis_tuser == REQ_RIGHT);
          res_speed <= '0;
          res_dv    <= 1'b0;
          res_drive <= '0;
        end
      end
      S_SUM: begin
        cnt     <= cnt + 1'b1;
        sum_acc <= sum_acc + (rd_ok ? SUM_W'(signed'(rd_data)) : '0);
      end
      S_SPD: neg <= spd_prod[DIV_W];
      S_SPDW: begin
        if (!div_busy) begin
          res_speed <= neg ? -14'(div_quo) : 14'(div_quo);
        end
      end
      S_ERR: begin
        err_r <= err;
        dif_r <= dif;
      end
      S_MP: acc <= mul_p;
      S_MI: acc <= acc + mul_p;
      S_MD: acc <= acc + mul_p;
      S_X:  x_r <= (32'(acc) <<< 3) + (32'(acc) <<< 1)
                   + (side ? -32'(dir_integ) : 32'(dir_integ));
      S_XC: neg <= xc[31];
      S_DRVW: begin
        if (!div_busy) begin
          res_dv <= 1'b1;
          if (div_quo > DIV_W'(DRIVE_MAX)) begin
            res_drive <= neg ? -$signed(DRIVE_MAX) : $signed(DRIVE_MAX);
          end else begin
            res_drive <= neg ? -10'(div_quo) : 10'(div_quo);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_side  <= res_side;
      out_speed <= res_speed;
      out_dv    <= res_dv;
      out_drive <= res_drive;
    end
  end

endmodule

// ===== tb/dual_wheel_pi_speed_controller_test.sv =====
// Self-checking testbench for the dual-wheel PI speed controller: directed table, then random
// ticks under several handshake idling phases, every result checked against an in-bench model
// or a literal expected word. Depends on dwpi_pkg and dual_wheel_pi_speed_controller.
module dual_wheel_pi_speed_controller_test;
  import dwpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 10;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_TICKS = 150;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic              side;
    logic signed [13:0] speed;
    logic              drive_valid;
    logic signed [9:0] drive;
  } wheel_res_t;

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [14:0]        val;
    logic [1:0]         req;
    logic signed [7:0]  tick;
    logic signed [15:0] target;
    bit                 has_lit;
    wheel_res_t         lit;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  dual_wheel_pi_speed_controller #(.HIST_DEPTH(HIST_DEPTH)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // register mirror
  logic [1:0] en_mask = RST_ENABLE_MASK;
  int gain_p = RST_PROP_GAIN;
  int gain_i = RST_INTEG_GAIN;
  int gain_d = RST_DIFF_GAIN;
  int lim_integ = RST_INTEG_LIMIT;
  int lim_dir = RST_DIR_LIMIT;
  int lim_out = RST_OUT_LIMIT;

  // controller state mirror
  logic signed [7:0] hist_l [HIST_DEPTH];
  logic signed [7:0] hist_r [HIST_DEPTH];
  int     slot_l = 0;
  int     slot_r = 0;
  longint integ_l = 0;
  longint integ_r = 0;
  longint dir_integ = 0;
  longint prev_err_l = 0;
  longint prev_err_r = 0;

  wheel_res_t expected_wheel_q[$];
  stim_row_t  directed_rows[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one controller step: measured speed, optional PI(D) update, history write, or a clear
  function automatic wheel_res_t compute_wheel_result(logic [1:0] req, logic signed [7:0] tick,
                                                      logic signed [15:0] target);
    wheel_res_t r;
    longint sum, speed, err, dif, a, o, drv, integ;
    bit is_right;
    r = '0;
    if (req == REQ_CLEAR) begin
      integ_l = 0;
      integ_r = 0;
      dir_integ = 0;
      return r;
    end
    if (req != REQ_LEFT && req != REQ_RIGHT) return r;
    is_right = (req == REQ_RIGHT);
    sum = tick;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      sum += is_right ? hist_r[k] : hist_l[k];
    end
    speed = (sum * SPEED_SCALE) / (HIST_DEPTH + 1);
    r.side = is_right;
    r.speed = speed[13:0];
    if (en_mask[is_right]) begin
      err = longint'(target) - speed;
      if (is_right) begin
        dif = err - prev_err_r;
        prev_err_r = err;
        integ_r = clamp_sym(integ_r + err, lim_integ);
        integ = integ_r;
        dir_integ = clamp_sym(dir_integ - err, lim_dir);
      end else begin
        dif = err - prev_err_l;
        prev_err_l = err;
        integ_l = clamp_sym(integ_l + err, lim_integ);
        integ = integ_l;
        dir_integ = clamp_sym(dir_integ + err, lim_dir);
      end
      a = gain_p * err + gain_i * integ + gain_d * dif;
      o = (DIR_DIVISOR * a + (is_right ? -dir_integ : dir_integ)) / DIR_DIVISOR;
      o = clamp_sym(o, lim_out);
      drv = clamp_sym(o / OUT_DIVISOR, longint'(DRIVE_MAX));
      r.drive_valid = 1'b1;
      r.drive = drv[9:0];
    end
    if (is_right) begin
      hist_r[slot_r] = tick;
      slot_r = (slot_r + 1) % HIST_DEPTH;
    end else begin
      hist_l[slot_l] = tick;
      slot_l = (slot_l + 1) % HIST_DEPTH;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    wheel_res_t got;
    wheel_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata[13:0], m_axis_tuser[1], m_axis_tdata[23:14]};
      if (expected_wheel_q.size() == 0) begin
        $display("%0t: unexpected word side=%0d speed=%0d valid=%0d drive=%0d", $time,
                 got.side, got.speed, got.drive_valid, got.drive);
        mismatch_count++;
      end else begin
        want = expected_wheel_q.pop_front();
        if (got.side !== want.side) begin
          $display("%0t: side expected %0d actual %0d", $time, want.side, got.side);
          mismatch_count++;
        end
        if (got.speed !== want.speed) begin
          $display("%0t: measured_speed expected %0d actual %0d", $time, want.speed, got.speed);
          mismatch_count++;
        end
        if (got.drive_valid !== want.drive_valid) begin
          $display("%0t: drive_valid expected %0d actual %0d", $time, want.drive_valid,
                   got.drive_valid);
          mismatch_count++;
        end
        if (got.drive !== want.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time, want.drive, got.drive);
          mismatch_count++;
        end
      end
    end
  end

  // caller sits at a falling edge; returns at a falling edge
  task automatic send_tick(logic [1:0] req, logic signed [7:0] tick, logic signed [15:0] target,
                           bit has_lit, wheel_res_t lit);
    wheel_res_t res;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {target, tick};
    s_axis_tuser <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = compute_wheel_result(req, tick, target);
    if (has_lit) res = lit;
    expected_wheel_q.push_back(res);
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_wheel_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE_MASK: en_mask = val[1:0];
      CFG_PROP_GAIN:   gain_p = val[7:0];
      CFG_INTEG_GAIN:  gain_i = val[7:0];
      CFG_DIFF_GAIN:   gain_d = val[7:0];
      CFG_INTEG_LIMIT: lim_integ = val;
      CFG_DIR_LIMIT:   lim_dir = val;
      CFG_OUT_LIMIT:   lim_out = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // zero, full scale or anything between
  function automatic logic [14:0] pick_setting(int maxv);
    case ($urandom_range(3))
      0: return '0;
      1: return 15'(maxv);
      default: return 15'($urandom_range(maxv));
    endcase
  endfunction

  task automatic load_random_settings();
    write_reg(CFG_ENABLE_MASK, ($urandom_range(3) == 0) ? 15'($urandom_range(3)) : 15'd3);
    write_reg(CFG_PROP_GAIN, pick_setting(255));
    write_reg(CFG_INTEG_GAIN, pick_setting(255));
    write_reg(CFG_DIFF_GAIN, pick_setting(255));
    write_reg(CFG_INTEG_LIMIT, pick_setting(32767));
    write_reg(CFG_DIR_LIMIT, pick_setting(32767));
    write_reg(CFG_OUT_LIMIT, pick_setting(32767));
  endtask

  task automatic add_cfg_row(logic [2:0] idx, logic [14:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    directed_rows.push_back(row);
  endtask

  task automatic add_tick_row(logic [1:0] req, logic signed [7:0] tick,
                              logic signed [15:0] target);
    stim_row_t row;
    row = '{default: '0};
    row.req = req;
    row.tick = tick;
    row.target = target;
    directed_rows.push_back(row);
  endtask

  task automatic add_known_row(logic [1:0] req, logic signed [7:0] tick,
                               logic signed [15:0] target, wheel_res_t lit);
    stim_row_t row;
    row = '{default: '0};
    row.req = req;
    row.tick = tick;
    row.target = target;
    row.has_lit = 1'b1;
    row.lit = lit;
    directed_rows.push_back(row);
  endtask

  initial begin
    logic [1:0]         req;
    logic signed [7:0]  tick;
    logic signed [15:0] target;
    int sent;
    int pick;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      hist_l[k] = '0;
      hist_r[k] = '0;
    end

    // drives disabled after reset: speed only
    add_known_row(REQ_LEFT, 8'sd0, 16'sd0, '{1'b0, 14'sd0, 1'b0, 10'sd0});
    add_known_row(REQ_LEFT, 8'sd127, 16'sd32767, '{1'b0, 14'sd577, 1'b0, 10'sd0});
    add_known_row(REQ_RIGHT, -8'sd128, -16'sd32768, '{1'b1, -14'sd581, 1'b0, 10'sd0});
    add_known_row(REQ_UNUSED, 8'sd127, 16'sd32767, '0);
    add_known_row(REQ_CLEAR, -8'sd1, -16'sd1, '0);
    add_cfg_row(CFG_ENABLE_MASK, 15'd3);
    add_tick_row(REQ_LEFT, 8'sd127, 16'sd32767);
    add_tick_row(REQ_RIGHT, -8'sd128, -16'sd32768);
    add_cfg_row(CFG_OUT_LIMIT, 15'd32767);
    add_tick_row(REQ_LEFT, 8'sd127, 16'sd32767);
    add_tick_row(REQ_RIGHT, -8'sd128, -16'sd32768);
    add_cfg_row(CFG_PROP_GAIN, 15'd255);
    add_cfg_row(CFG_INTEG_GAIN, 15'd255);
    add_cfg_row(CFG_DIFF_GAIN, 15'd255);
    add_tick_row(REQ_LEFT, -8'sd128, 16'sd32767);
    add_tick_row(REQ_RIGHT, 8'sd127, -16'sd32768);
    add_tick_row(REQ_LEFT, 8'sd0, 16'sd0);
    add_tick_row(REQ_RIGHT, 8'sd0, 16'sd0);
    add_known_row(REQ_CLEAR, 8'sd0, 16'sd0, '0);
    add_cfg_row(CFG_INTEG_LIMIT, 15'd0);
    add_cfg_row(CFG_DIR_LIMIT, 15'd0);
    add_cfg_row(CFG_OUT_LIMIT, 15'd0);
    add_tick_row(REQ_LEFT, 8'sd3, 16'sd200);
    add_tick_row(REQ_RIGHT, -8'sd3, -16'sd200);
    add_cfg_row(CFG_ENABLE_MASK, 15'd1);
    add_tick_row(REQ_RIGHT, 8'sd10, 16'sd1000);
    add_tick_row(REQ_LEFT, 8'sd10, 16'sd1000);
    add_cfg_row(CFG_ENABLE_MASK, 15'd2);
    add_tick_row(REQ_LEFT, -8'sd10, -16'sd1000);
    add_tick_row(REQ_RIGHT, -8'sd10, -16'sd1000);
    add_cfg_row(CFG_PROP_GAIN, RST_PROP_GAIN);
    add_cfg_row(CFG_INTEG_GAIN, RST_INTEG_GAIN);
    add_cfg_row(CFG_DIFF_GAIN, RST_DIFF_GAIN);
    add_cfg_row(CFG_INTEG_LIMIT, RST_INTEG_LIMIT);
    add_cfg_row(CFG_DIR_LIMIT, RST_DIR_LIMIT);
    add_cfg_row(CFG_OUT_LIMIT, RST_OUT_LIMIT);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_tick(directed_rows[i].req, directed_rows[i].tick, directed_rows[i].target,
                  directed_rows[i].has_lit, directed_rows[i].lit);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      load_random_settings();
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 79; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 79; end
        default: begin send_gap_pct = 32; stall_pct = 32; end
      endcase
      sent = 0;
      while (sent < PHASE_TICKS) begin
        pick = $urandom_range(99);
        if (pick < 46) req = REQ_LEFT;
        else if (pick < 92) req = REQ_RIGHT;
        else if (pick < 97) req = REQ_CLEAR;
        else req = REQ_UNUSED;
        // half the ticks slow so the history sum stays near zero now and then
        tick = ($urandom_range(1) == 0) ? 8'($urandom_range(16)) - 8'sd8 : 8'($urandom);
        target = ($urandom_range(4) < 3) ? 16'($urandom_range(1600)) - 16'sd800
                                         : 16'($urandom);
        send_tick(req, tick, target, 1'b0, '0);
        if (req != REQ_UNUSED) sent++;
        if (phase == 1 && sent == PHASE_TICKS / 2) drain_results();
      end
    end

    drain_results();
    repeat (HIST_DEPTH + 40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dwpi_pkg.sv
src/dual_wheel_pi_speed_controller.sv
tb/dual_wheel_pi_speed_controller_test.sv
